// ----- hw/rtl/ulcr_pkg.sv -----
// ulcr_pkg: shared types and constants of the used-level compaction and remap block
// no dependencies; imported by the controller, datapath and top level
package ulcr_pkg;

   // number of table slots the level field can address
   localparam int TABLE_SLOTS = 16;

   // command codes carried on req_cmd
   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_MARK  = 3'd1;
   localparam logic [2:0] CMD_EMIT  = 3'd2;
   localparam logic [2:0] CMD_REMAP = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   // reset value of the level count register
   localparam logic [4:0] NUM_LEVELS_RESET = 5'd16;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SUM,
      ST_EMIT,
      ST_REMAP
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;     // transaction accepted this cycle
      logic count_load;  // register half counts of the marks
      logic sum_load;    // add half counts, clear scan
      logic scan_step;   // advance the emit scan
      logic load_emit;   // load one kept entry into the output register
      logic load_empty;  // load the nothing-kept result
      logic load_remap;  // load the remap result
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_remap;    // captured command is a remap
      logic kept_zero;   // no level is kept
      logic scan_done;   // scan reached the effective level count
      logic scan_marked; // current scan slot is marked
      logic out_free;    // output register can take a result
   } dp_status_type;

   // population count of an eight bit group
   function automatic logic [3:0] popcount8(input logic [7:0] bits);
      logic [3:0] cnt;
      cnt = 4'd0;
      for (int i = 0; i < 8; i++) begin
         cnt = cnt + {3'd0, bits[i]};
      end
      return cnt;
   endfunction

endpackage

// ----- hw/rtl/ulcr_ctrl.sv -----
// ulcr_ctrl: sequencer of the used-level compaction and remap block
// depends on ulcr_pkg; drives the datapath through ctrl_cmd_type
module ulcr_ctrl
   import ulcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [2:0]    req_cmd,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_cmd == CMD_EMIT || req_cmd == CMD_REMAP) begin
                  state_in = ST_COUNT;
               end
            end
         end
         ST_COUNT: begin
            cmd.count_load = 1'b1;
            state_in       = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_load = 1'b1;
            state_in     = status.is_remap ? ST_REMAP : ST_EMIT;
         end
         ST_EMIT: begin
            if (status.kept_zero) begin
               if (status.out_free) begin
                  cmd.load_empty = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (status.scan_done) begin
               state_in = ST_IDLE;
            end else if (!status.scan_marked) begin
               cmd.scan_step = 1'b1;
            end else if (status.out_free) begin
               cmd.load_emit = 1'b1;
               cmd.scan_step = 1'b1;
            end
         end
         ST_REMAP: begin
            if (status.out_free) begin
               cmd.load_remap = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/ulcr_datapath.sv -----
// ulcr_datapath: level table, used marks, counters and output register
// depends on ulcr_pkg; commanded by ulcr_ctrl
module ulcr_datapath
   import ulcr_pkg::*;
#(
   parameter int MAX_LEVELS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [4:0]    csr_wdata,
   input  logic [2:0]    req_cmd,
   input  logic [3:0]    req_level,
   input  logic [7:0]    req_qp_value,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [3:0]    rsp_new_index,
   output logic [7:0]    rsp_kept_value,
   output logic [4:0]    rsp_kept_count,
   output logic          rsp_last,
   output logic          rsp_empty_or_unused
);

   localparam int SLOT_CNT = (MAX_LEVELS < TABLE_SLOTS) ? MAX_LEVELS : TABLE_SLOTS;
   localparam int IDX_W    = $clog2(SLOT_CNT);
   localparam logic [4:0] LIM_CAP = 5'(SLOT_CNT);

   logic [7:0]          table_ff [SLOT_CNT];
   logic [SLOT_CNT-1:0] marks_ff;
   logic [4:0]          num_levels_ff;
   logic                is_remap_ff;
   logic [3:0]          level_ff;
   logic [3:0]          lim_lo_ff, lim_hi_ff, lvl_lo_ff, lvl_hi_ff;
   logic [4:0]          kept_ff;
   logic [4:0]          index_ff;
   logic [4:0]          scan_ff;
   logic [4:0]          pos_ff;
   logic                rsp_valid_ff;
   logic [3:0]          rsp_new_index_ff;
   logic [7:0]          rsp_kept_value_ff;
   logic [4:0]          rsp_kept_count_ff;
   logic                rsp_last_ff;
   logic                rsp_flag_ff;

   logic [4:0]  lim;
   logic [15:0] lim_vec;
   logic [15:0] lvl_vec;
   logic        level_in_range;
   logic        remap_used;
   logic        out_free;

   // effective level count
   assign lim = (num_levels_ff > LIM_CAP) ? LIM_CAP : num_levels_ff;

   assign level_in_range = ({1'b0, req_level} < LIM_CAP);

   // marks below the level count and below the captured level
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (i < SLOT_CNT) begin
            lim_vec[i] = marks_ff[i] && (5'(i) < lim);
            lvl_vec[i] = marks_ff[i] && (5'(i) < {1'b0, level_ff});
         end else begin
            lim_vec[i] = 1'b0;
            lvl_vec[i] = 1'b0;
         end
      end
   end

   assign remap_used = ({1'b0, level_ff} < lim) && marks_ff[level_ff[IDX_W-1:0]];
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff <= NUM_LEVELS_RESET;
      end else if (csr_we) begin
         num_levels_ff <= csr_wdata;
      end
   end

   // table writes
   always_ff @(posedge clock) begin
      if (cmd.capture && req_cmd == CMD_WRITE && level_in_range) begin
         table_ff[req_level[IDX_W-1:0]] <= req_qp_value;
      end
   end

   // used marks
   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
      end else if (cmd.capture && req_cmd == CMD_CLEAR) begin
         marks_ff <= '0;
      end else if (cmd.capture && req_cmd == CMD_MARK && level_in_range) begin
         marks_ff[req_level[IDX_W-1:0]] <= 1'b1;
      end
   end

   // captured transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_remap_ff <= (req_cmd == CMD_REMAP);
         level_ff    <= req_level;
      end
   end

   // half counts, then sums
   always_ff @(posedge clock) begin
      if (cmd.count_load) begin
         lim_lo_ff <= popcount8(lim_vec[7:0]);
         lim_hi_ff <= popcount8(lim_vec[15:8]);
         lvl_lo_ff <= popcount8(lvl_vec[7:0]);
         lvl_hi_ff <= popcount8(lvl_vec[15:8]);
      end
      if (cmd.sum_load) begin
         kept_ff  <= {1'b0, lim_lo_ff} + {1'b0, lim_hi_ff};
         index_ff <= {1'b0, lvl_lo_ff} + {1'b0, lvl_hi_ff};
      end
   end

   // emit scan position and output position
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         pos_ff  <= '0;
      end else if (cmd.sum_load) begin
         scan_ff <= '0;
         pos_ff  <= '0;
      end else begin
         if (cmd.scan_step) begin
            scan_ff <= scan_ff + 5'd1;
         end
         if (cmd.load_emit) begin
            pos_ff <= pos_ff + 5'd1;
         end
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_emit || cmd.load_empty || cmd.load_remap) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (cmd.load_emit) begin
         rsp_new_index_ff  <= pos_ff[3:0];
         rsp_kept_value_ff <= table_ff[scan_ff[IDX_W-1:0]];
         rsp_kept_count_ff <= kept_ff;
         rsp_last_ff       <= ((pos_ff + 5'd1) == kept_ff);
         rsp_flag_ff       <= 1'b0;
      end else if (cmd.load_empty) begin
         rsp_new_index_ff  <= '0;
         rsp_kept_value_ff <= '0;
         rsp_kept_count_ff <= '0;
         rsp_last_ff       <= 1'b1;
         rsp_flag_ff       <= 1'b1;
      end else if (cmd.load_remap) begin
         rsp_new_index_ff  <= remap_used ? index_ff[3:0] : 4'd0;
         rsp_kept_value_ff <= '0;
         rsp_kept_count_ff <= kept_ff;
         rsp_last_ff       <= 1'b1;
         rsp_flag_ff       <= !remap_used;
      end
   end

   // status to controller
   assign status.is_remap    = is_remap_ff;
   assign status.kept_zero   = (kept_ff == 5'd0);
   assign status.scan_done   = (scan_ff >= lim);
   assign status.scan_marked = marks_ff[scan_ff[IDX_W-1:0]];
   assign status.out_free    = out_free;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_index       = rsp_new_index_ff;
   assign rsp_kept_value      = rsp_kept_value_ff;
   assign rsp_kept_count      = rsp_kept_count_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_empty_or_unused = rsp_flag_ff;

endmodule

// ----- hw/rtl/used_level_compaction_remap.sv -----
// used_level_compaction_remap: top level, joins the controller and the datapath
// depends on ulcr_pkg, ulcr_ctrl and ulcr_datapath
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_ready  cmd, level, qp_value
//   rsp_      out         rsp_valid/rsp_ready  new_index, kept_value, kept_count, last, flag
//   csr_      in          csr_we               num_levels
//
// write, mark and clear are accepted one per cycle
// remap registers the mark count in the count and sum states, then loads the output in
// the remap state once the output register is free; no request is taken until idle again
// emit runs the same count and sum states, then scans the effective levels, holding on a
// marked level while the output is full; the nothing-kept case loads its flagged result
// instead; a stalled rsp_ready holds the output and a scan at a marked level; reset
// clears the marks and output valid, sets the level count to 16, keeps the table contents
module used_level_compaction_remap
   import ulcr_pkg::*;
#(
   parameter int MAX_LEVELS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [3:0] req_level,
   input  logic [7:0] req_qp_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_new_index,
   output logic [7:0] rsp_kept_value,
   output logic [4:0] rsp_kept_count,
   output logic       rsp_last,
   output logic       rsp_empty_or_unused,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   ulcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, counters and output register
   ulcr_datapath #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_cmd             (req_cmd),
      .req_level           (req_level),
      .req_qp_value        (req_qp_value),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_new_index       (rsp_new_index),
      .rsp_kept_value      (rsp_kept_value),
      .rsp_kept_count      (rsp_kept_count),
      .rsp_last            (rsp_last),
      .rsp_empty_or_unused (rsp_empty_or_unused)
   );

endmodule

// ----- hw/rtl/ulcr_checker.sv -----
// ulcr_checker: port-level assertions for used_level_compaction_remap
// depends on the top level ports only; attached by the bind below
module ulcr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_new_index,
   input logic [7:0] rsp_kept_value,
   input logic [4:0] rsp_kept_count,
   input logic       rsp_last,
   input logic       rsp_empty_or_unused
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_index)
         && $stable(rsp_kept_value) && $stable(rsp_kept_count)
         && $stable(rsp_last) && $stable(rsp_empty_or_unused))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // flagged results carry index zero
   a_flag_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_or_unused |-> rsp_new_index == 4'd0)
      else $error("flagged result with nonzero index");

   // a non-final emit entry sits below the kept count minus one
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_empty_or_unused
         && (({1'b0, rsp_new_index} + 5'd1) < rsp_kept_count))
      else $error("non-final entry out of order");

   // count never exceeds the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kept_count <= 5'd16)
      else $error("kept count out of range");

endmodule

bind used_level_compaction_remap ulcr_checker u_ulcr_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_new_index       (rsp_new_index),
   .rsp_kept_value      (rsp_kept_value),
   .rsp_kept_count      (rsp_kept_count),
   .rsp_last            (rsp_last),
   .rsp_empty_or_unused (rsp_empty_or_unused)
);

// ----- verif/ulcr_remap_checker.sv -----
// ulcr_remap_checker: watches the request, result and register ports of the compaction
// and remap block, predicts every result and compares it field by field
// depends on ulcr_pkg for the command codes, table size and level count reset value
module ulcr_remap_checker
   import ulcr_pkg::*;
#(
   parameter int MAX_LEVELS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [3:0] req_level,
   input  logic [7:0] req_qp_value,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [3:0] rsp_new_index,
   input  logic [7:0] rsp_kept_value,
   input  logic [4:0] rsp_kept_count,
   input  logic       rsp_last,
   input  logic       rsp_empty_or_unused,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata,
   output int         outstanding,
   output int         results_checked,
   output int         error_count
);

   // one result transaction as the block presents it
   typedef struct packed {
      logic [3:0] new_index;
      logic [7:0] kept_value;
      logic [4:0] kept_count;
      logic       last;
      logic       empty_or_unused;
   } level_result_type;

   // shadow of the block's table, marks and level count
   logic [7:0]       qp_table [TABLE_SLOTS];
   logic             used_mark [TABLE_SLOTS];
   logic [4:0]       level_count;
   level_result_type predicted_q [$];
   level_result_type oldest;
   int               mismatches = 0;
   int               compared = 0;

   assign error_count     = mismatches;
   assign results_checked = compared;

   // levels taking part: the register clipped to the table and the parameter
   function automatic int effective_levels();
      int lim;
      lim = int'(level_count);
      if (lim > MAX_LEVELS) lim = MAX_LEVELS;
      if (lim > TABLE_SLOTS) lim = TABLE_SLOTS;
      return lim;
   endfunction

   // number of marked levels below a bound
   function automatic int marks_below(input int bound);
      int cnt;
      cnt = 0;
      for (int i = 0; i < bound; i++) begin
         if (used_mark[i]) cnt++;
      end
      return cnt;
   endfunction

   // apply one accepted request to the shadow state and queue its results
   task automatic predict_compaction(input logic [2:0] cmd, input logic [3:0] level,
                                     input logic [7:0] qp);
      int               lim;
      int               kept;
      int               pos;
      level_result_type res;
      lim  = effective_levels();
      kept = marks_below(lim);
      res  = '0;
      case (cmd)
         CMD_WRITE: begin
            if (level < MAX_LEVELS) qp_table[level] = qp;
         end
         CMD_MARK: begin
            if (level < MAX_LEVELS) used_mark[level] = 1'b1;
         end
         CMD_EMIT: begin
            if (kept == 0) begin
               // nothing kept: a single flagged result
               res.last            = 1'b1;
               res.empty_or_unused = 1'b1;
               predicted_q.push_back(res);
            end else begin
               pos = 0;
               for (int i = 0; i < lim; i++) begin
                  if (used_mark[i]) begin
                     res.new_index       = pos[3:0];
                     res.kept_value      = qp_table[i];
                     res.kept_count      = kept[4:0];
                     res.last            = (pos + 1 == kept);
                     res.empty_or_unused = 1'b0;
                     predicted_q.push_back(res);
                     pos++;
                  end
               end
            end
         end
         CMD_REMAP: begin
            res.kept_count = kept[4:0];
            res.last       = 1'b1;
            if (level < lim && used_mark[level]) begin
               res.new_index = 4'(marks_below(int'(level)));
            end else begin
               // unmarked or beyond the effective levels
               res.empty_or_unused = 1'b1;
            end
            predicted_q.push_back(res);
         end
         CMD_CLEAR: begin
            for (int i = 0; i < TABLE_SLOTS; i++) used_mark[i] = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // sample all ports at the edge, compare before predicting so that a result
   // is never matched against a transaction accepted at the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) used_mark[i] = 1'b0;
         level_count = NUM_LEVELS_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_q.size() == 0) begin
               $display("%0t: result with nothing expected, actual index %0d value %0d count %0d",
                        $time, rsp_new_index, rsp_kept_value, rsp_kept_count);
               mismatches++;
            end else begin
               oldest = predicted_q.pop_front();
               check_field("new_index", 32'(oldest.new_index), 32'(rsp_new_index));
               check_field("kept_value", 32'(oldest.kept_value), 32'(rsp_kept_value));
               check_field("kept_count", 32'(oldest.kept_count), 32'(rsp_kept_count));
               check_field("last", 32'(oldest.last), 32'(rsp_last));
               check_field("empty_or_unused", 32'(oldest.empty_or_unused),
                           32'(rsp_empty_or_unused));
               compared++;
            end
         end
         if (csr_we) level_count = csr_wdata;
         if (req_valid && req_ready) predict_compaction(req_cmd, req_level, req_qp_value);
      end
      outstanding <= predicted_q.size();
   end

endmodule

// ----- verif/tb_used_level_compaction_remap.sv -----
// tb_used_level_compaction_remap: clock, reset, stimulus and verdict for the block
// depends on ulcr_pkg, used_level_compaction_remap and ulcr_remap_checker
module tb_used_level_compaction_remap
   import ulcr_pkg::*;
;

   localparam int MAX_LEVELS    = 16;
   localparam int RANDOM_ITEMS  = 130;
   localparam int SETTLE_CYCLES = 30;
   localparam int STALL_CYCLES  = 200;
   localparam int STALL_AFTER   = 100;
   localparam int STALL_REMAPS  = 8;

   // command values the block ignores
   localparam logic [2:0] CMD_NONE_FIRST = 3'd5;
   localparam logic [2:0] CMD_NONE_LAST  = 3'd7;

   // level count settings at and beyond the ends of the range
   localparam logic [4:0] LEVELS_ZERO = 5'd0;
   localparam logic [4:0] LEVELS_ONE  = 5'd1;
   localparam logic [4:0] LEVELS_FULL = 5'd16;
   localparam logic [4:0] LEVELS_SAT  = 5'd31;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_cmd = CMD_WRITE;
   logic [3:0] req_level = 4'd0;
   logic [7:0] req_qp_value = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_new_index;
   logic [7:0] rsp_kept_value;
   logic [4:0] rsp_kept_count;
   logic       rsp_last;
   logic       rsp_empty_or_unused;
   logic       csr_we = 1'b0;
   logic [4:0] csr_wdata = 5'd0;

   int outstanding;
   int results_checked;
   int error_count;
   int item_count = 0;
   int useful_count = 0;
   int setting_count = 0;
   bit steady = 1'b0;
   bit stall_go = 1'b0;
   bit stall_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   used_level_compaction_remap #(
      .MAX_LEVELS(MAX_LEVELS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_level          (req_level),
      .req_qp_value       (req_qp_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_new_index      (rsp_new_index),
      .rsp_kept_value     (rsp_kept_value),
      .rsp_kept_count     (rsp_kept_count),
      .rsp_last           (rsp_last),
      .rsp_empty_or_unused(rsp_empty_or_unused),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   ulcr_remap_checker #(
      .MAX_LEVELS(MAX_LEVELS)
   ) checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_level          (req_level),
      .req_qp_value       (req_qp_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_new_index      (rsp_new_index),
      .rsp_kept_value     (rsp_kept_value),
      .rsp_kept_count     (rsp_kept_count),
      .rsp_last           (rsp_last),
      .rsp_empty_or_unused(rsp_empty_or_unused),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .outstanding        (outstanding),
      .results_checked    (results_checked),
      .error_count        (error_count)
   );

   // idle length: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // offer one request transaction and hold it until accepted
   task automatic send_req(input logic [2:0] cmd, input logic [3:0] level,
                           input logic [7:0] qp);
      int gap;
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_level    <= level;
      req_qp_value <= qp;
      do @(posedge clock); while (!req_ready);
      item_count++;
      if (cmd <= CMD_CLEAR) useful_count++;
   endtask

   // stray request with fully random fields
   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0)
         send_req(3'($urandom_range(CMD_WRITE, CMD_NONE_LAST)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
   endtask

   // stop offering and wait until every predicted result has come out
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_levels(input logic [4:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      setting_count++;
   endtask

   // result side: random ready runs and gaps, one long hold-off mid-run
   initial begin
      int left;
      bit ready_level;
      left        = 0;
      ready_level = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_go && !stall_done) begin
            stall_done = 1'b1;
            repeat (STALL_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
            left = 0;
         end
         if (left == 0) begin
            ready_level = !ready_level;
            left        = ready_level ? $urandom_range(1, 40) : idle_gap();
         end
         if (left > 0) begin
            rsp_ready <= ready_level;
            left--;
            @(posedge clock);
         end
      end
   end

   // stimulus: directed opening, then frames of mark, emit and remap passes
   initial begin
      int          frame;
      int          n;
      int          base;
      int          r;
      logic [4:0]  extremes [4];
      extremes = '{LEVELS_ZERO, LEVELS_ONE, LEVELS_SAT, LEVELS_FULL};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table so that no emit reads an unwritten entry
      send_req(CMD_WRITE, 4'd0, 8'd0);
      for (int i = 1; i < 15; i++) send_req(CMD_WRITE, 4'(i), 8'((i * 37) & 255));
      send_req(CMD_WRITE, 4'd15, 8'd255);

      // nothing marked yet
      send_req(CMD_EMIT, 4'd0, 8'd0);
      // lowest, highest and a middle level marked
      send_req(CMD_MARK, 4'd0, 8'd255);
      send_req(CMD_MARK, 4'd15, 8'd0);
      send_req(CMD_MARK, 4'd7, 8'd0);
      send_req(CMD_EMIT, 4'd15, 8'd255);
      send_req(CMD_REMAP, 4'd0, 8'd0);
      send_req(CMD_REMAP, 4'd15, 8'd0);
      send_req(CMD_REMAP, 4'd5, 8'd0);
      // ignored command values
      send_req(CMD_NONE_FIRST, 4'd3, 8'd9);
      send_req(CMD_NONE_LAST, 4'd12, 8'd200);
      // cleared marks, then empty emit and unused remap
      send_req(CMD_CLEAR, 4'd0, 8'd0);
      send_req(CMD_EMIT, 4'd0, 8'd0);
      send_req(CMD_REMAP, 4'd7, 8'd0);

      base  = useful_count;
      frame = 0;
      while (useful_count < base + RANDOM_ITEMS) begin
         settle();
         steady = 1'b0;
         if (frame < 4) begin
            set_levels(extremes[frame]);
         end else if ($urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, 9);
            if (r == 0) set_levels(5'($urandom_range(17, 31)));
            else if (r == 1) set_levels(LEVELS_ZERO);
            else set_levels(5'($urandom_range(1, 16)));
         end
         steady = ($urandom_range(0, 3) == 0);

         // refresh a few table entries
         n = $urandom_range(0, 3);
         repeat (n) send_req(CMD_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         // usually start the frame from clean marks
         if ($urandom_range(0, 4) != 0)
            send_req(CMD_CLEAR, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         // mark pass
         n = $urandom_range(1, 12);
         repeat (n) begin
            maybe_noise();
            send_req(CMD_MARK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         end
         // compaction run, occasionally skipped
         if ($urandom_range(0, 7) != 0)
            send_req(CMD_EMIT, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         // remap pass; once past the stall point a long one runs into the held-off result side
         if (!stall_go && item_count >= STALL_AFTER) begin
            stall_go = 1'b1;
            n        = STALL_REMAPS;
         end else begin
            n = $urandom_range(1, 10);
         end
         repeat (n) begin
            maybe_noise();
            send_req(CMD_REMAP, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         end
         frame++;
      end

      settle();
      $display("covered %0d requests in %0d frames over %0d level count settings",
               item_count, frame, setting_count);
      $display("compared %0d results against the prediction", results_checked);
      if (error_count == 0) begin
         $display("[used_level_compaction_remap] OK");
      end else begin
         $display("[used_level_compaction_remap] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10000000;
      $display("[used_level_compaction_remap] ERROR");
      $finish;
   end

endmodule
